@@ hw/rtl/evt2_pkg.sv @@
// shared types and constants of the evt2 event decoder
`timescale 1ns / 1ps
`default_nettype none

package evt2_pkg;

	// word type codes in bits 31..28
	localparam logic [3:0] TYPE_CD_OFF      = 4'h0;
	localparam logic [3:0] TYPE_CD_ON       = 4'h1;
	localparam logic [3:0] TYPE_TIME_HIGH   = 4'h8;
	localparam logic [3:0] TYPE_EXT_TRIGGER = 4'hA;
	localparam logic [3:0] TYPE_OTHERS      = 4'hE;
	localparam logic [3:0] TYPE_CONTINUED   = 4'hF;

	// field positions inside a word
	localparam int TYPE_LSB = 28;
	localparam int TLOW_LSB = 22;
	localparam int X_LSB    = 11;

	localparam int WORD_W   = 32;
	localparam int TYPE_W   = 4;
	localparam int BODY_W   = 28;
	localparam int TLOW_W   = 6;
	localparam int ADDR_W   = 11;
	localparam int TS_W     = 34;
	localparam int COUNT_W  = 32;

	// class of a word after the front stage
	typedef enum logic [1:0] {
		KIND_CD,
		KIND_TIME_HIGH,
		KIND_UNKNOWN,
		KIND_SKIP
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_EVENT    = 2'd0,
		ST_UNKNOWN  = 2'd1,
		ST_TS_BACK  = 2'd2,
		ST_RESERVED = 2'd3
	} status_t;

	// classified word handed from front to back
	typedef struct packed {
		kind_t              kind;
		logic               pol;
		logic [BODY_W-1:0]  body;
	} rec_t;

	// one result beat
	typedef struct packed {
		status_t            status;
		logic [TS_W-1:0]    timestamp;
		logic [ADDR_W-1:0]  x_addr;
		logic [ADDR_W-1:0]  y_addr;
		logic               polarity;
		logic               last;
	} res_t;

endpackage

`default_nettype wire

@@ hw/rtl/evt2_queue.sv @@
// small first-word-fall-through queue built from flops
`timescale 1ns / 1ps
`default_nettype none

module evt2_queue #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  empty,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// handshake qualification
	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/evt2_front.sv @@
// front stage: accepts raw words, classifies them, drops skipped types
`timescale 1ns / 1ps
`default_nettype none

module evt2_front
	import evt2_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [WORD_W-1:0] word,
	output logic                   full,
	output logic                   rec_push,
	output rec_t                   rec_data,
	input  wire logic              rec_full
);

	logic [TYPE_W-1:0] wtype;
	kind_t             kind;
	logic              accept;
	logic              valid_s1;
	rec_t              rec_s1;

	assign wtype = word[TYPE_LSB +: TYPE_W];

	// word type decode
	always_comb begin
		case (wtype)
			TYPE_CD_OFF, TYPE_CD_ON:                      kind = KIND_CD;
			TYPE_TIME_HIGH:                               kind = KIND_TIME_HIGH;
			TYPE_EXT_TRIGGER, TYPE_OTHERS, TYPE_CONTINUED: kind = KIND_SKIP;
			default:                                      kind = KIND_UNKNOWN;
		endcase
	end

	// stage stalls only when it holds a beat the queue cannot take
	assign full     = valid_s1 && rec_full;
	assign accept   = push && !full;
	assign rec_push = valid_s1 && !rec_full;
	assign rec_data = rec_s1;

	// classified word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (kind != KIND_SKIP);
		end else if (rec_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_s1.kind <= kind;
			rec_s1.pol  <= (wtype == TYPE_CD_ON);
			rec_s1.body <= word[BODY_W-1:0];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/evt2_back.sv @@
// back stage: keeps decoder state, checks time order, builds results
`timescale 1ns / 1ps
`default_nettype none

module evt2_back
	import evt2_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [COUNT_W-1:0] cfg_data,
	input  wire logic               rec_empty,
	input  wire rec_t               rec_data,
	output logic                    rec_pop,
	input  wire logic               res_full,
	output logic                    res_push,
	output res_t                    res_data
);

	logic [COUNT_W-1:0] max_events_q;
	logic [BODY_W-1:0]  stored_th_q;
	logic [TS_W-1:0]    prev_time_q;
	logic [COUNT_W-1:0] done_q;
	logic               halted_q;

	logic               go;
	logic               active;
	logic [TS_W-1:0]    ts;
	logic               ts_back;
	logic [COUNT_W-1:0] done_next;

	// take a beat whenever the result queue has room
	assign go      = !rec_empty && !res_full;
	assign rec_pop = go;

	assign active    = !halted_q && (done_q < max_events_q);
	assign ts        = {stored_th_q, rec_data.body[TLOW_LSB +: TLOW_W]};
	assign ts_back   = (ts < prev_time_q);
	assign done_next = done_q + 1'b1;

	// result selection
	always_comb begin
		res_push = 1'b0;
		res_data = '0;
		if (go && active) begin
			case (rec_data.kind)
				KIND_CD: begin
					res_push = 1'b1;
					if (ts_back) begin
						res_data.status = ST_TS_BACK;
					end else begin
						res_data.status    = ST_EVENT;
						res_data.timestamp = ts;
						res_data.x_addr    = rec_data.body[X_LSB +: ADDR_W];
						res_data.y_addr    = rec_data.body[ADDR_W-1:0];
						res_data.polarity  = rec_data.pol;
						res_data.last      = (done_next == max_events_q);
					end
				end
				KIND_UNKNOWN: begin
					res_push        = 1'b1;
					res_data.status = ST_UNKNOWN;
				end
				default: begin
					res_push = 1'b0;
				end
			endcase
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_events_q <= '1;
			stored_th_q  <= '0;
			prev_time_q  <= '0;
			done_q       <= '0;
			halted_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_events_q <= cfg_data;
			end
			if (go && active) begin
				case (rec_data.kind)
					KIND_CD: begin
						if (ts_back) begin
							halted_q <= 1'b1;
						end else begin
							prev_time_q <= ts;
							done_q      <= done_next;
						end
					end
					KIND_TIME_HIGH: begin
						stored_th_q <= rec_data.body;
					end
					KIND_UNKNOWN: begin
						halted_q <= 1'b1;
					end
					default: begin
						halted_q <= halted_q;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/evt2_event_decoder.sv @@
// top level of the evt2 event-stream decoder
// Input channel: a raw 32-bit word is taken at a clock edge with push high
// and full low. Result channel: while empty is low the oldest result sits on
// status, timestamp, x_addr, y_addr, polarity and last; it is taken at an
// edge with pop high. Configuration: cfg_we writes cfg_data into the event
// count limit (reset value all ones); the user must write it only while the
// block is idle, which the block itself does not enforce. Throughput is one
// word per clock while full is low. A word passes a classify register, a
// small queue and the execute stage before its result lands in the output
// queue. Time-high and skipped words give no result. An unknown type or a
// timestamp going backwards gives one error result and halts the block until
// reset; once the event limit is reached further words are dropped.
// When pop is held low the output queue fills, the execute stage stops, the
// middle queue fills and full rises; nothing is lost. Reset clears all
// queues, the stored time, the event count and the halt flag.
`timescale 1ns / 1ps
`default_nettype none

module evt2_event_decoder
	import evt2_pkg::*;
#(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [COUNT_W-1:0] cfg_data,
	input  wire logic               push,
	input  wire logic [WORD_W-1:0]  word,
	output logic                    full,
	input  wire logic               pop,
	output logic                    empty,
	output logic [1:0]              status,
	output logic [TS_W-1:0]         timestamp,
	output logic [ADDR_W-1:0]       x_addr,
	output logic [ADDR_W-1:0]       y_addr,
	output logic                    polarity,
	output logic                    last
);

	logic                rec_push;
	rec_t                rec_in;
	logic                rec_full;
	logic                rec_pop;
	logic                rec_empty;
	logic [$bits(rec_t)-1:0] rec_out_bits;
	rec_t                rec_out;
	logic                res_push;
	res_t                res_in;
	logic                res_full;
	logic [$bits(res_t)-1:0] res_out_bits;
	res_t                res_out;

	// classify stage
	evt2_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.word     (word),
		.full     (full),
		.rec_push (rec_push),
		.rec_data (rec_in),
		.rec_full (rec_full)
	);

	// decoupling queue between front and back
	evt2_queue #(
		.DEPTH (MID_DEPTH),
		.WIDTH ($bits(rec_t))
	) u_mid_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.push_data (rec_in),
		.full      (rec_full),
		.pop       (rec_pop),
		.empty     (rec_empty),
		.pop_data  (rec_out_bits)
	);

	assign rec_out = rec_t'(rec_out_bits);

	// execute stage
	evt2_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.rec_empty (rec_empty),
		.rec_data  (rec_out),
		.rec_pop   (rec_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_in)
	);

	// result queue
	evt2_queue #(
		.DEPTH (OUT_DEPTH),
		.WIDTH ($bits(res_t))
	) u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_in),
		.full      (res_full),
		.pop       (pop),
		.empty     (empty),
		.pop_data  (res_out_bits)
	);

	// result fields
	assign res_out   = res_t'(res_out_bits);
	assign status    = res_out.status;
	assign timestamp = res_out.timestamp;
	assign x_addr    = res_out.x_addr;
	assign y_addr    = res_out.y_addr;
	assign polarity  = res_out.polarity;
	assign last      = res_out.last;

endmodule

`default_nettype wire
